>>> rtl/egcd_pkg.sv
// Shared package for the Euclid GCD unit: field widths, the default
// operand width and the command/status structs between controller and datapath.
// No dependencies.
package egcd_pkg;

  localparam int DATA_W            = 32;
  localparam int STEP_W            = 6;
  localparam int OPERAND_WIDTH_DEF = 32;
  localparam int IN_TDATA_W        = 64;
  localparam int OUT_TDATA_W       = 40;

  localparam logic [STEP_W-1:0] STEP_MAX = 6'd63;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture operands, order them, clear counters
    logic shift;  // one restoring-division bit
    logic swap;   // pair becomes (divisor, remainder), count a step
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic zero_op;   // an operand was zero
    logic div_last;  // this shift handles the last dividend bit of the division
    logic rem_zero;  // remainder of the finished division is zero
  } stat_t;

endpackage

>>> rtl/egcd_dp.sv
// Datapath of the Euclid GCD unit: operand registers, bit-serial restoring
// remainder unit and saturating step counter.
// Depends on egcd_pkg.
module egcd_dp #(
  parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic [egcd_pkg::DATA_W-1:0]   operand_a,
  input  logic [egcd_pkg::DATA_W-1:0]   operand_b,
  input  egcd_pkg::cmd_t                cmd,
  output egcd_pkg::stat_t               stat,
  output logic [egcd_pkg::DATA_W-1:0]   gcd_value,
  output logic [egcd_pkg::STEP_W-1:0]   step_count,
  output logic                          zero_operand_error
);

  // operands arrive as 32-bit fields; only the low OPERAND_WIDTH bits (at most 32) count
  localparam int OpW  = (OPERAND_WIDTH < egcd_pkg::DATA_W) ? OPERAND_WIDTH
                                                           : egcd_pkg::DATA_W;
  localparam int CntW = $clog2(OpW);

  logic [OpW-1:0]              dvs_r, dvd_r, rem_r;
  logic [CntW-1:0]             cnt_r;
  logic [egcd_pkg::STEP_W-1:0] steps_r;
  logic                        err_r;

  logic [OpW-1:0] a_op, b_op;
  logic [OpW:0]   rem_sh, rem_sub;
  logic           ge;

  assign a_op    = operand_a[OpW-1:0];
  assign b_op    = operand_b[OpW-1:0];
  // shift next dividend bit into the partial remainder, try the subtract
  assign rem_sh  = {rem_r, dvd_r[OpW-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvs_r   <= (a_op < b_op) ? a_op : b_op;
      dvd_r   <= (a_op < b_op) ? b_op : a_op;
      rem_r   <= '0;
      cnt_r   <= '0;
      steps_r <= '0;
      err_r   <= (a_op == '0) || (b_op == '0);
    end else if (cmd.shift) begin
      rem_r <= ge ? rem_sub[OpW-1:0] : rem_sh[OpW-1:0];
      dvd_r <= {dvd_r[OpW-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end else if (cmd.swap) begin
      dvd_r <= dvs_r;
      dvs_r <= rem_r;
      rem_r <= '0;
      cnt_r <= '0;
      if (steps_r != egcd_pkg::STEP_MAX) begin
        steps_r <= steps_r + 1'b1;
      end
    end
  end

  assign stat.zero_op  = err_r;
  assign stat.div_last = (cnt_r == CntW'(OpW - 1));
  assign stat.rem_zero = (rem_r == '0);

  assign gcd_value          = err_r ? '0 : egcd_pkg::DATA_W'(dvs_r);
  assign step_count         = err_r ? '0 : steps_r;
  assign zero_operand_error = err_r;

endmodule

>>> rtl/egcd_ctrl.sv
// Controller of the Euclid GCD unit: sequences load, division bits and
// pair swaps, and hands the finished result to the output register.
// Depends on egcd_pkg.
module egcd_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  input  egcd_pkg::stat_t stat,
  output egcd_pkg::cmd_t  cmd,
  output logic            in_ready,
  output logic            out_load
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_DIV,
    S_EVAL,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = stat.zero_op ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.shift = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.rem_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.swap  = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/euclid_gcd_with_step_count_unit.sv
// Euclid GCD unit with remainder step count, top level.
// The accepted pair is loaded and ordered, then each remainder step runs a
//   bit-serial division over the operand width and an evaluation, until a zero
//   remainder ends it; a zero operand goes from the start state to the result.
// The bit-serial remainder unit makes one bit per cycle. A new pair is taken only
//   after the last has left the loop; the next pair enters while a result waits.
// Reset (rst_n low, synchronous) returns the controller to idle and empties the
//   output register. Depends on egcd_pkg, egcd_ctrl and egcd_dp.
module euclid_gcd_with_step_count_unit #(
  parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [31:0] operand_a, [63:32] operand_b
  input  logic [egcd_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result channel
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] gcd_value, [37:32] step_count, [39:38] zero fill
  output logic [egcd_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] zero_operand_error
  output logic                                out_tuser
);

  egcd_pkg::cmd_t  cmd;
  egcd_pkg::stat_t stat;

  logic                        out_free, out_load;
  logic [egcd_pkg::DATA_W-1:0] dp_gcd;
  logic [egcd_pkg::STEP_W-1:0] dp_steps;
  logic                        dp_err;

  // output register: parts the result channel from the iteration loop
  logic                        out_valid_r, out_valid_nxt;
  logic [egcd_pkg::DATA_W-1:0] out_gcd_r;
  logic [egcd_pkg::STEP_W-1:0] out_steps_r;
  logic                        out_err_r;

  // free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;

  egcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .in_ready (in_tready),
    .out_load (out_load)
  );

  egcd_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk                (clk),
    .operand_a          (in_tdata[egcd_pkg::DATA_W-1:0]),
    .operand_b          (in_tdata[egcd_pkg::IN_TDATA_W-1:egcd_pkg::DATA_W]),
    .cmd                (cmd),
    .stat               (stat),
    .gcd_value          (dp_gcd),
    .step_count         (dp_steps),
    .zero_operand_error (dp_err)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: capture the finished result, hold while stalled
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_gcd_r   <= dp_gcd;
      out_steps_r <= dp_steps;
      out_err_r   <= dp_err;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_steps_r, out_gcd_r};
  assign out_tuser  = out_err_r;

endmodule
